/* hdl/jbr_pkg.sv */
`default_nettype none
package jbr_pkg;

    // Ring size default, handed to the top level parameter
    localparam int RING_DEPTH_DEF = 4096;

    // CRC-16-CCITT, MSB first
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Request function codes
    localparam logic [2:0] FN_CLEAR   = 3'd0;
    localparam logic [2:0] FN_BEGIN   = 3'd1;
    localparam logic [2:0] FN_WRITE   = 3'd2;
    localparam logic [2:0] FN_FINISH  = 3'd3;
    localparam logic [2:0] FN_READ    = 3'd4;
    localparam logic [2:0] FN_SET_ALL = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_BAD_JOB    = 3'd2;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd3;
    localparam logic [2:0] ST_BAD_CRC    = 3'd4;
    localparam logic [2:0] ST_INTERNAL   = 3'd5;
    localparam logic [2:0] ST_EMPTY      = 3'd6;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] job_id;
        logic [31:0] byte_total;
        logic [15:0] want_crc;
        logic [31:0] offset;
        logic [7:0]  data_byte;
        logic        chunk_first;
        logic [15:0] chunk_len;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        read_valid;
        logic [7:0]  read_data;
        logic [31:0] received_count;
        logic [31:0] consumed_count;
        logic [12:0] available_count;
        logic [15:0] running_crc;
        logic        job_ready;
        logic        all_received;
    } t_res;

endpackage
`default_nettype wire

/* hdl/jbr_req_if.sv */
`default_nettype none
interface jbr_req_if;
    logic         valid;
    logic         ready;
    jbr_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/jbr_res_if.sv */
`default_nettype none
interface jbr_res_if;
    logic         valid;
    logic         ready;
    jbr_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/job_byte_ring_with_crc_check.sv */
`default_nettype none
// Byte ring that takes in one job at a time. Each request carries a function
// code (clear, begin, write byte, finish, read byte, set all received) and
// returns exactly one result with a status and the current counters, CRC and
// flags. Payload bytes go into a RING_DEPTH-byte block RAM and are folded into
// a CRC-16-CCITT (init 0xFFFF). The ring RAM read is registered, so the byte of a
// read that returns one reaches the result register in the cycle after the request
// is taken. Results sit in an output register; a new request is taken in the same
// cycle that the waiting result is taken, or whenever that register is empty and
// no read byte is on its way from the RAM.
module job_byte_ring_with_crc_check #(
    parameter int RING_DEPTH = jbr_pkg::RING_DEPTH_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    jbr_req_if.sink   i_req,
    jbr_res_if.source o_res
);
    import jbr_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Job state
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_fill, n_fill;
    logic [31:0]   r_job, n_job;
    logic [CW-1:0] r_job_size, n_job_size;
    logic [31:0]   r_rcvd, n_rcvd;
    logic [31:0]   r_cons, n_cons;
    logic [15:0]   r_scrc, n_scrc;
    logic [15:0]   r_crc, n_crc;
    logic          r_recv, n_recv;
    logic          r_rdy, n_rdy;
    logic          r_all, n_all;
    logic [15:0]   r_chunk_rem, n_chunk_rem;
    logic [2:0]    r_verdict, n_verdict;

    // Result path
    logic          r_out_valid, n_out_valid;
    logic          r_rd_pend, n_rd_pend;
    t_res          r_out, n_out;

    logic          req_acc;
    logic          res_take;
    logic          ram_we;
    logic [7:0]    ram_rdata;
    logic          take_byte;
    logic          rd_hit;
    logic [2:0]    st;
    logic [2:0]    v;
    logic [31:0]   free_space;

    assign res_take    = r_out_valid && o_res.ready;
    assign i_req.ready = !r_rd_pend && (!r_out_valid || o_res.ready);
    assign req_acc     = i_req.valid && i_req.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign free_space  = 32'(RING_DEPTH) - 32'(r_fill);

    jbr_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_req.data.data_byte),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    // Decode the request and compute the next job state
    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_fill      = r_fill;
        n_job       = r_job;
        n_job_size  = r_job_size;
        n_rcvd      = r_rcvd;
        n_cons      = r_cons;
        n_scrc      = r_scrc;
        n_crc       = r_crc;
        n_recv      = r_recv;
        n_rdy       = r_rdy;
        n_all       = r_all;
        n_chunk_rem = r_chunk_rem;
        n_verdict   = r_verdict;
        ram_we      = 1'b0;
        take_byte   = 1'b0;
        rd_hit      = 1'b0;
        st          = ST_OK;
        v           = ST_OK;

        if (req_acc) begin
            unique case (i_req.data.func)
                FN_CLEAR, FN_BEGIN: begin
                    if (i_req.data.func == FN_BEGIN &&
                        (i_req.data.byte_total == 32'd0 ||
                         i_req.data.byte_total > 32'(RING_DEPTH))) begin
                        st = ST_NO_SPACE;
                    end else begin
                        n_wp        = '0;
                        n_rp        = '0;
                        n_fill      = '0;
                        n_job       = '0;
                        n_job_size  = '0;
                        n_rcvd      = '0;
                        n_cons      = '0;
                        n_scrc      = '0;
                        n_crc       = CRC_INIT;
                        n_recv      = 1'b0;
                        n_rdy       = 1'b0;
                        n_all       = 1'b0;
                        n_chunk_rem = '0;
                        n_verdict   = ST_OK;
                        if (i_req.data.func == FN_BEGIN) begin
                            n_job      = i_req.data.job_id;
                            n_job_size = CW'(i_req.data.byte_total);
                            n_scrc     = i_req.data.want_crc;
                            n_recv     = 1'b1;
                        end
                    end
                end
                FN_WRITE: begin
                    if (!i_req.data.chunk_first) begin
                        if (r_chunk_rem == 16'd0) begin
                            st = ST_INTERNAL;
                        end else begin
                            n_chunk_rem = r_chunk_rem - 16'd1;
                            if (r_verdict != ST_OK) begin
                                st = r_verdict;
                            end else begin
                                take_byte = 1'b1;
                            end
                        end
                    end else begin
                        if (!r_recv || i_req.data.job_id != r_job) begin
                            v = ST_BAD_JOB;
                        end else if (i_req.data.chunk_len == 16'd0) begin
                            v = ST_INTERNAL;
                        end else if (i_req.data.offset != r_rcvd) begin
                            v = ST_BAD_OFFSET;
                        end else if (32'(i_req.data.chunk_len) > free_space) begin
                            v = ST_NO_SPACE;
                        end
                        n_verdict   = v;
                        n_chunk_rem = (i_req.data.chunk_len != 16'd0) ?
                                      i_req.data.chunk_len - 16'd1 : 16'd0;
                        if (v != ST_OK) begin
                            st = v;
                        end else begin
                            take_byte = 1'b1;
                        end
                    end
                end
                FN_FINISH: begin
                    if (!r_recv || i_req.data.job_id != r_job ||
                        i_req.data.byte_total != 32'(r_job_size)) begin
                        st = ST_BAD_JOB;
                    end else if (r_rcvd != 32'(r_job_size)) begin
                        st = ST_BAD_OFFSET;
                    end else if (i_req.data.want_crc != 16'd0 &&
                                 i_req.data.want_crc != r_scrc) begin
                        st = ST_BAD_CRC;
                    end else if (r_scrc != 16'd0 && r_crc != r_scrc) begin
                        st = ST_BAD_CRC;
                    end else begin
                        n_recv = 1'b0;
                        n_rdy  = 1'b1;
                    end
                end
                FN_READ: begin
                    if (r_fill == '0) begin
                        st = ST_EMPTY;
                    end else begin
                        rd_hit = 1'b1;
                        n_rp   = (r_rp == PW'(RING_DEPTH - 1)) ? '0 : r_rp + PW'(1);
                        n_fill = r_fill - CW'(1);
                        n_cons = r_cons + 32'd1;
                    end
                end
                FN_SET_ALL: begin
                    n_all = 1'b1;
                end
                default: begin
                    st = ST_INTERNAL;
                end
            endcase

            // Store an admitted byte and fold it into the CRC
            if (take_byte) begin
                if (r_fill >= CW'(RING_DEPTH)) begin
                    st = ST_NO_SPACE;
                end else begin
                    ram_we = 1'b1;
                    n_wp   = (r_wp == PW'(RING_DEPTH - 1)) ? '0 : r_wp + PW'(1);
                    n_fill = r_fill + CW'(1);
                    n_crc  = crc_byte(r_crc, i_req.data.data_byte);
                    n_rcvd = r_rcvd + 32'd1;
                end
            end
        end
    end

    // Build the result; a read fills in its byte in the following cycle
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !res_take;
        n_rd_pend   = 1'b0;
        if (req_acc) begin
            n_out.status          = st;
            n_out.read_valid      = rd_hit;
            n_out.read_data       = 8'd0;
            n_out.received_count  = n_rcvd;
            n_out.consumed_count  = n_cons;
            n_out.available_count = 13'(n_fill);
            n_out.running_crc     = n_crc;
            n_out.job_ready       = n_rdy;
            n_out.all_received    = n_all;
            n_rd_pend             = rd_hit;
            n_out_valid           = !rd_hit;
        end else if (r_rd_pend) begin
            n_out.read_data = ram_rdata;
            n_out_valid     = 1'b1;
        end
    end

    // Advance control and job state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_job       <= '0;
            r_job_size  <= '0;
            r_rcvd      <= '0;
            r_cons      <= '0;
            r_scrc      <= '0;
            r_crc       <= CRC_INIT;
            r_recv      <= 1'b0;
            r_rdy       <= 1'b0;
            r_all       <= 1'b0;
            r_chunk_rem <= '0;
            r_verdict   <= ST_OK;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_fill      <= n_fill;
            r_job       <= n_job;
            r_job_size  <= n_job_size;
            r_rcvd      <= n_rcvd;
            r_cons      <= n_cons;
            r_scrc      <= n_scrc;
            r_crc       <= n_crc;
            r_recv      <= n_recv;
            r_rdy       <= n_rdy;
            r_all       <= n_all;
            r_chunk_rem <= n_chunk_rem;
            r_verdict   <= n_verdict;
            r_out_valid <= n_out_valid;
            r_rd_pend   <= n_rd_pend;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
`default_nettype wire

/* hdl/jbr_ram.sv */
`default_nettype none
module jbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = jbr_pkg::RING_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
